@@ src/vpv_pkg.sv @@
package vpv_pkg;

  // input beat
  typedef struct packed {
    logic [7:0] path_byte;
    logic       last_byte;
    logic       empty_string;
  } vpv_in_t;

  // result beat
  typedef struct packed {
    logic        path_ok;
    logic [2:0]  error_code;
    logic [12:0] root_length;
    logic [12:0] name_start;
  } vpv_out_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic take;   // a byte is consumed
    logic slash;
    logic legal;
    logic fin;    // path ends with this beat
  } vpv_cls_t;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_CW    = 3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_FORM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;

  localparam logic [1:0] FORM_ABS  = 2'd0;
  localparam logic [1:0] FORM_REL  = 2'd1;
  localparam logic [1:0] FORM_ROOT = 2'd2;

  localparam logic [12:0] MAX_LENGTH_RST = 13'd256;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EMPTY     = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
  localparam logic [2:0] ERR_SLASH     = 3'd3;
  localparam logic [2:0] ERR_EMPTY_SEG = 3'd4;
  localparam logic [2:0] ERR_ILLEGAL   = 3'd5;
  localparam logic [2:0] ERR_NO_NAME   = 3'd6;
  localparam logic [2:0] ERR_BAD_ROOT  = 3'd7;

endpackage

@@ src/vpv_front.sv @@
module vpv_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  vpv_pkg::vpv_in_t  in_data,
  input  logic              q_full,
  output logic              q_push,
  output vpv_pkg::vpv_cls_t q_item
);
  import vpv_pkg::*;

  localparam logic [7:0] CH_SLASH = 8'h2F;

  function automatic logic legal_byte(input logic [7:0] b);
    logic ok;
    begin
      ok = 1'b1;
      if (b < 8'h20 || b == 8'h7F) begin
        ok = 1'b0;
      end else if (b < 8'h80) begin
        case (b)
          8'h2F, 8'h5C, 8'h2E, 8'h3A, 8'h22,
          8'h7C, 8'h3F, 8'h2A, 8'h3C, 8'h3E: ok = 1'b0;
          default:                           ok = 1'b1;
        endcase
      end
      return ok;
    end
  endfunction

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // an empty-string beat ends the path without consuming its byte
  always_comb begin
    q_item.take  = !in_data.empty_string;
    q_item.slash = (in_data.path_byte == CH_SLASH);
    q_item.legal = legal_byte(in_data.path_byte);
    q_item.fin   = in_data.empty_string || in_data.last_byte;
  end

endmodule

@@ src/vpv_fifo.sv @@
module vpv_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vpv_pkg::vpv_cls_t push_item,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop,
  output vpv_pkg::vpv_cls_t pop_item
);
  import vpv_pkg::*;

  vpv_cls_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == Q_CW'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == Q_CW'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue pop lost");

endmodule

@@ src/vpv_back.sv @@
module vpv_back #(
  parameter int unsigned MAX_PATH_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        path_form,
  input  logic [12:0]       max_length,
  input  logic              q_valid,
  input  vpv_pkg::vpv_cls_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output vpv_pkg::vpv_out_t out_data
);
  import vpv_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PATH_BYTES + 3);
  localparam int unsigned CMP_W = (CNT_W > 13) ? CNT_W + 1 : 14;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_PATH_BYTES + 2);
  localparam logic [CMP_W-1:0] LIM_MAX = CMP_W'(MAX_PATH_BYTES);

  logic [CNT_W-1:0] cnt_r, cnt_u, cnt_nxt;
  logic [1:0]       idx_r, idx_u, idx_nxt;
  logic             seg_empty_r, seg_empty_u, seg_empty_nxt;
  logic [2:0]       ferr_r, ferr_u, ferr_nxt;
  logic [CNT_W-1:0] root_r, root_u, root_nxt;
  logic [CNT_W-1:0] slash_r, slash_u, slash_nxt;
  logic             lead_r, lead_u, lead_nxt;

  logic             out_valid_r, out_valid_nxt;
  vpv_out_t         out_data_r, res;

  logic             pop, finish;
  logic [CMP_W-1:0] n_w, lim_w, maxl_w, root_w, name_w;
  logic [2:0]       err;
  logic             root_ok;

  assign pop    = q_valid && (!q_item.fin || !out_valid_r || out_ready);
  assign finish = pop && q_item.fin;
  assign q_pop  = pop;

  // per-byte state update
  always_comb begin
    cnt_u       = cnt_r;
    idx_u       = idx_r;
    seg_empty_u = seg_empty_r;
    ferr_u      = ferr_r;
    root_u      = root_r;
    slash_u     = slash_r;
    lead_u      = lead_r;
    if (pop && q_item.take) begin
      if (cnt_r != CNT_SAT) begin
        cnt_u = cnt_r + 1'b1;
      end
      if (cnt_r == '0 && q_item.slash) begin
        lead_u = 1'b1;
      end else if (q_item.slash) begin
        if (seg_empty_r && ferr_r == ERR_NONE) begin
          ferr_u = ERR_EMPTY_SEG;
        end
        if (idx_r == 2'd0) begin
          root_u = cnt_r - CNT_W'(lead_r);
        end
        if (idx_r != 2'd2) begin
          idx_u = idx_r + 1'b1;
        end
        seg_empty_u = 1'b1;
        slash_u     = cnt_r;
      end else begin
        if (!q_item.legal && ferr_r == ERR_NONE) begin
          ferr_u = ERR_ILLEGAL;
        end
        seg_empty_u = 1'b0;
      end
    end
  end

  // end-of-path evaluation on the updated state
  always_comb begin
    n_w     = CMP_W'(cnt_u);
    maxl_w  = CMP_W'(max_length);
    lim_w   = (maxl_w < LIM_MAX) ? maxl_w : LIM_MAX;
    root_w  = CMP_W'(root_u);
    name_w  = CMP_W'(slash_u) + 1'b1;
    root_ok = (n_w >= CMP_W'(2)) && ((n_w - 1'b1) <= lim_w) && lead_u
              && (idx_u == 2'd0) && (ferr_u == ERR_NONE);
    res.root_length = '0;
    res.name_start  = '0;
    if (path_form == FORM_ROOT) begin
      err = root_ok ? ERR_NONE : ERR_BAD_ROOT;
    end else if (n_w == '0) begin
      err = ERR_EMPTY;
    end else if (n_w > lim_w) begin
      err = ERR_TOO_LONG;
    end else if (path_form == FORM_REL) begin
      if (lead_u) begin
        err = ERR_SLASH;
      end else if (ferr_u != ERR_NONE) begin
        err = ferr_u;
      end else begin
        err = seg_empty_u ? ERR_EMPTY_SEG : ERR_NONE;
      end
    end else begin
      // absolute form; the unused form code lands here too
      if (!lead_u) begin
        err = ERR_SLASH;
      end else if (ferr_u != ERR_NONE) begin
        err = ferr_u;
      end else if (seg_empty_u) begin
        err = ERR_EMPTY_SEG;
      end else if (idx_u == 2'd0) begin
        err = ERR_NO_NAME;
      end else begin
        err = ERR_NONE;
        res.root_length = root_w[12:0];
        res.name_start  = name_w[12:0];
      end
    end
    res.path_ok    = (err == ERR_NONE);
    res.error_code = err;
  end

  always_comb begin
    cnt_nxt       = finish ? '0 : cnt_u;
    idx_nxt       = finish ? 2'd0 : idx_u;
    seg_empty_nxt = finish ? 1'b1 : seg_empty_u;
    ferr_nxt      = finish ? ERR_NONE : ferr_u;
    root_nxt      = finish ? '0 : root_u;
    slash_nxt     = finish ? '0 : slash_u;
    lead_nxt      = finish ? 1'b0 : lead_u;
    out_valid_nxt = finish || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= 2'd0;
      seg_empty_r <= 1'b1;
      ferr_r      <= ERR_NONE;
      root_r      <= '0;
      slash_r     <= '0;
      lead_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      seg_empty_r <= seg_empty_nxt;
      ferr_r      <= ferr_nxt;
      root_r      <= root_nxt;
      slash_r     <= slash_nxt;
      lead_r      <= lead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (cnt_r == '0 && seg_empty_r && ferr_r == ERR_NONE && !lead_r))
    else $error("path state not cleared after final beat");

  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.path_ok == (out_data_r.error_code == ERR_NONE)))
    else $error("path_ok disagrees with error_code");

  a_fields_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.path_ok) |->
      (out_data_r.root_length == '0 && out_data_r.name_start == '0))
    else $error("position fields set on a failed path");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !finish)
    else $error("result overwritten before it was taken");

endmodule

@@ src/virtual_path_validator.sv @@
// channel  | ports                          | beat
// ---------+--------------------------------+----------------------------------------
// in       | in_valid, in_ready, in_data    | one path byte with last/empty flags
// out      | out_valid, out_ready, out_data | one verdict per ended path
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//
// One byte a cycle sustained unless out_ready stalls a final byte: the front classifies a
// byte in the cycle it is taken and queues it; the back updates the path counters one
// queued byte per cycle. A verdict is registered on the edge that pops the final byte;
// that byte is always written into the queue first, even with the queue empty.
// Reset clears the queue, the path state and loads path_form 0, max_length 256.
// A stalled output holds back only final bytes; the four-entry queue absorbs the rest
// before in_ready drops.
module virtual_path_validator #(
  parameter int unsigned MAX_PATH_BYTES = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vpv_pkg::vpv_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vpv_pkg::vpv_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vpv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vpv_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import vpv_pkg::*;

  logic [1:0]  path_form_r;
  logic [12:0] max_length_r;

  logic        q_full, q_push, q_valid, q_pop;
  vpv_cls_t    push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_form_r  <= FORM_ABS;
      max_length_r <= MAX_LENGTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PATH_FORM:  path_form_r  <= cfg_data[1:0];
        CFG_MAX_LENGTH: max_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vpv_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  vpv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (pop_item)
  );

  vpv_back #(
    .MAX_PATH_BYTES (MAX_PATH_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .path_form  (path_form_r),
    .max_length (max_length_r),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
